/* design/stlfw_pkg.sv */
// Package for the serial text LCD frame writer: op codes, wire constants,
// microcode control word type and the microprogram ROM. No dependencies.
`default_nettype none

package stlfw_pkg;

  // Default text row length in bytes.
  localparam int ROW_BYTES_DEF = 16;

  // Input op codes.
  localparam logic [2:0] OP_CMD   = 3'd0;
  localparam logic [2:0] OP_DATA  = 3'd1;
  localparam logic [2:0] OP_BEGIN = 3'd2;
  localparam logic [2:0] OP_CHAR  = 3'd3;
  localparam logic [2:0] OP_REV   = 3'd4;

  // Bytes and commands seen on the serial line.
  localparam logic [7:0] SYNC_CMD     = 8'hF8;
  localparam logic [7:0] SYNC_DATA    = 8'hFA;
  localparam logic [7:0] NIBBLE_MASK  = 8'hF0;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CMD_BASIC    = 8'h30;
  localparam logic [7:0] CMD_EXTENDED = 8'h34;
  localparam logic [7:0] CMD_REVERSE  = 8'h14;
  localparam logic [4:0] POS_LIMIT    = 5'd31;

  // Byte source select of a microstep.
  localparam logic [1:0] SRC_SYNC_CMD  = 2'd0;
  localparam logic [1:0] SRC_SYNC_DATA = 2'd1;
  localparam logic [1:0] SRC_HI        = 2'd2;
  localparam logic [1:0] SRC_LO        = 2'd3;

  // Operand select of a microstep.
  localparam logic [2:0] OPND_INPUT = 3'd0;
  localparam logic [2:0] OPND_BASIC = 3'd1;
  localparam logic [2:0] OPND_POS   = 3'd2;
  localparam logic [2:0] OPND_EXT   = 3'd3;
  localparam logic [2:0] OPND_REV   = 3'd4;
  localparam logic [2:0] OPND_SPACE = 3'd5;

  // Microprogram entry points.
  localparam int UA_W = 5;
  localparam logic [UA_W-1:0] UA_CMD   = 5'd0;
  localparam logic [UA_W-1:0] UA_DATA  = 5'd3;
  localparam logic [UA_W-1:0] UA_BEGIN = 5'd6;
  localparam logic [UA_W-1:0] UA_REV   = 5'd12;
  localparam logic [UA_W-1:0] UA_CHAR  = 5'd18;
  localparam logic [UA_W-1:0] UA_PAD   = 5'd21;

  // One control word per microstep; each step emits one wire byte.
  typedef struct packed {
    logic [1:0]      src;
    logic [2:0]      opnd;
    logic            frame_end;
    logic            done;
    logic            loop;
    logic [UA_W-1:0] target;
  } ucw_t;

  function automatic ucw_t mk(input logic [1:0] src, input logic [2:0] opnd,
                              input logic fe, input logic done);
    ucw_t w;
    w.src       = src;
    w.opnd      = opnd;
    w.frame_end = fe;
    w.done      = done;
    w.loop      = 1'b0;
    w.target    = UA_CMD;
    return w;
  endfunction

  // Microprogram ROM.
  function automatic ucw_t uc_rom(input logic [UA_W-1:0] addr);
    ucw_t w;
    case (addr)
      // Raw command frame.
      5'd0:  w = mk(SRC_SYNC_CMD,  OPND_INPUT, 1'b0, 1'b0);
      5'd1:  w = mk(SRC_HI,        OPND_INPUT, 1'b0, 1'b0);
      5'd2:  w = mk(SRC_LO,        OPND_INPUT, 1'b1, 1'b1);
      // Raw data frame.
      5'd3:  w = mk(SRC_SYNC_DATA, OPND_INPUT, 1'b0, 1'b0);
      5'd4:  w = mk(SRC_HI,        OPND_INPUT, 1'b0, 1'b0);
      5'd5:  w = mk(SRC_LO,        OPND_INPUT, 1'b1, 1'b1);
      // Begin text: basic instruction set, then position.
      5'd6:  w = mk(SRC_SYNC_CMD,  OPND_BASIC, 1'b0, 1'b0);
      5'd7:  w = mk(SRC_HI,        OPND_BASIC, 1'b0, 1'b0);
      5'd8:  w = mk(SRC_LO,        OPND_BASIC, 1'b1, 1'b0);
      5'd9:  w = mk(SRC_SYNC_CMD,  OPND_POS,   1'b0, 1'b0);
      5'd10: w = mk(SRC_HI,        OPND_POS,   1'b0, 1'b0);
      5'd11: w = mk(SRC_LO,        OPND_POS,   1'b1, 1'b1);
      // Reverse row: extended instruction set, then reverse command.
      5'd12: w = mk(SRC_SYNC_CMD,  OPND_EXT,   1'b0, 1'b0);
      5'd13: w = mk(SRC_HI,        OPND_EXT,   1'b0, 1'b0);
      5'd14: w = mk(SRC_LO,        OPND_EXT,   1'b1, 1'b0);
      5'd15: w = mk(SRC_SYNC_CMD,  OPND_REV,   1'b0, 1'b0);
      5'd16: w = mk(SRC_HI,        OPND_REV,   1'b0, 1'b0);
      5'd17: w = mk(SRC_LO,        OPND_REV,   1'b1, 1'b1);
      // Text character frame.
      5'd18: w = mk(SRC_SYNC_DATA, OPND_INPUT, 1'b0, 1'b0);
      5'd19: w = mk(SRC_HI,        OPND_INPUT, 1'b0, 1'b0);
      5'd20: w = mk(SRC_LO,        OPND_INPUT, 1'b1, 1'b1);
      // Space padding loop: jumps back while positions remain.
      5'd21: w = mk(SRC_SYNC_DATA, OPND_SPACE, 1'b0, 1'b0);
      5'd22: w = mk(SRC_HI,        OPND_SPACE, 1'b0, 1'b0);
      5'd23: begin
        w        = mk(SRC_LO, OPND_SPACE, 1'b1, 1'b1);
        w.loop   = 1'b1;
        w.target = UA_PAD;
      end
      default: w = mk(SRC_SYNC_CMD, OPND_INPUT, 1'b1, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/stlfw_byte_unit.sv */
// Datapath of the frame writer: selects the operand of a microstep and forms
// the wire byte from it. Depends on stlfw_pkg.
`default_nettype none

module stlfw_byte_unit (
  input  wire stlfw_pkg::ucw_t cw,
  input  wire logic [7:0]      value,
  input  wire logic [1:0]      row,
  input  wire logic [2:0]      col,
  output logic      [7:0]      wire_byte
);

  logic [7:0] opnd;
  logic [7:0] row_base;

  // Position base per display row; col never carries past the low nibble.
  always_comb begin
    case (row)
      2'd0:    row_base = 8'h80;
      2'd1:    row_base = 8'h90;
      2'd2:    row_base = 8'h88;
      default: row_base = 8'h98;
    endcase
  end

  // Operand select.
  always_comb begin
    case (cw.opnd)
      stlfw_pkg::OPND_INPUT: opnd = value;
      stlfw_pkg::OPND_BASIC: opnd = stlfw_pkg::CMD_BASIC;
      stlfw_pkg::OPND_POS:   opnd = row_base + {5'd0, col};
      stlfw_pkg::OPND_EXT:   opnd = stlfw_pkg::CMD_EXTENDED;
      stlfw_pkg::OPND_REV:   opnd = stlfw_pkg::CMD_REVERSE | {6'd0, row};
      stlfw_pkg::OPND_SPACE: opnd = stlfw_pkg::SPACE_CHAR;
      default:               opnd = value;
    endcase
  end

  // Byte of the frame: sync, high nibble, or low nibble moved up.
  always_comb begin
    case (cw.src)
      stlfw_pkg::SRC_SYNC_CMD:  wire_byte = stlfw_pkg::SYNC_CMD;
      stlfw_pkg::SRC_SYNC_DATA: wire_byte = stlfw_pkg::SYNC_DATA;
      stlfw_pkg::SRC_HI:        wire_byte = opnd & stlfw_pkg::NIBBLE_MASK;
      default:                  wire_byte = {opnd[3:0], 4'd0};
    endcase
  end

endmodule

`default_nettype wire

/* design/serial_text_lcd_frame_writer.sv */
// Top level of the serial text LCD frame writer: item decode, microcode
// sequencer, text row state and output register. Depends on stlfw_pkg and
// stlfw_byte_unit.
//
// Usage: each input beat carries one op (raw command, raw data, begin text
// row, text character, reverse row). The block answers with the wire bytes
// of the serial frames, one byte per output beat; out_tuser marks the third
// byte of a frame and out_tlast the final byte caused by the input beat.
// Items that cause no bytes (characters without an open row, a NUL without
// padding, unknown ops) only update the text state and are taken at once.
// A microprogram step counter walks a ROM, one step per wire byte; a frame is
// three bytes, begin text and reverse row two frames each, and space padding
// one frame per remaining position. The next item is accepted in the cycle
// the last byte enters the output register. The step register and then the
// output register lie between acceptance and the first byte on the output,
// and an output stall can hold the step between them.
// A stall on the output holds the output register and the step counter.
// Reset (synchronous, active low) empties the output, stops the sequencer
// and closes any open text row.
`default_nettype none

module serial_text_lcd_frame_writer #(
  parameter int ROW_BYTES = stlfw_pkg::ROW_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // row[1:0], col[4:2], fill[5], value[13:6], zero
  input  wire logic [2:0]  in_tuser,   // op[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // wire_byte[7:0]
  output logic             out_tuser,  // frame_end[0]
  output logic             out_tlast
);

  localparam logic [5:0] ROW_LEN = 6'(ROW_BYTES);

  // Input fields.
  logic [2:0] in_op;
  logic [1:0] in_row;
  logic [2:0] in_col;
  logic       in_fill;
  logic [7:0] in_value;

  assign in_op    = in_tuser;
  assign in_row   = in_tdata[1:0];
  assign in_col   = in_tdata[4:2];
  assign in_fill  = in_tdata[5];
  assign in_value = in_tdata[13:6];

  // Sequencer and text state registers.
  logic                       busy_r, busy_nxt;
  logic [stlfw_pkg::UA_W-1:0] step_r, step_nxt;
  logic [4:0]                 loop_cnt_r, loop_cnt_nxt;
  logic                       text_active_r, text_active_nxt;
  logic [4:0]                 pos_left_r, pos_left_nxt;
  logic                       pad_r, pad_nxt;

  // Operand registers, loaded at acceptance.
  logic [7:0] value_r;
  logic [1:0] row_r;
  logic [2:0] col_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_fe_r, out_fe_nxt;
  logic       out_last_r, out_last_nxt;

  stlfw_pkg::ucw_t cw;
  logic [7:0]      step_byte;
  logic            adv;
  logic            jump;
  logic            finish;
  logic            acc;
  logic [5:0]      span;
  logic [5:0]      row_count;
  logic [4:0]      begin_count;

  // Current control word.
  assign cw = stlfw_pkg::uc_rom(step_r);

  stlfw_byte_unit u_byte (
    .cw        (cw),
    .value     (value_r),
    .row       (row_r),
    .col       (col_r),
    .wire_byte (step_byte)
  );

  // Step control: advance when the output register can take a byte.
  assign adv       = busy_r && (!out_valid_r || out_tready);
  assign jump      = cw.loop && (loop_cnt_r != 5'd1);
  assign finish    = adv && cw.done && !jump;
  assign in_tready = !busy_r || finish;
  assign acc       = in_tvalid && in_tready;

  // Row length for a begin item, saturated to the position counter.
  always_comb begin
    span      = {2'd0, in_col, 1'b0};
    row_count = (ROW_LEN > span) ? (ROW_LEN - span) : 6'd0;
    if (row_count > {1'b0, stlfw_pkg::POS_LIMIT}) begin
      begin_count = stlfw_pkg::POS_LIMIT;
    end else begin
      begin_count = row_count[4:0];
    end
  end

  // Sequencer, decode and text state.
  always_comb begin
    busy_nxt        = busy_r;
    step_nxt        = step_r;
    loop_cnt_nxt    = loop_cnt_r;
    text_active_nxt = text_active_r;
    pos_left_nxt    = pos_left_r;
    pad_nxt         = pad_r;

    if (adv) begin
      step_nxt = jump ? cw.target : step_r + 1'b1;
      if (cw.loop) begin
        loop_cnt_nxt = loop_cnt_r - 1'b1;
      end
      if (finish) begin
        busy_nxt = 1'b0;
      end
    end

    if (acc) begin
      case (in_op)
        stlfw_pkg::OP_CMD: begin
          busy_nxt = 1'b1;
          step_nxt = stlfw_pkg::UA_CMD;
        end
        stlfw_pkg::OP_DATA: begin
          busy_nxt = 1'b1;
          step_nxt = stlfw_pkg::UA_DATA;
        end
        stlfw_pkg::OP_BEGIN: begin
          busy_nxt        = 1'b1;
          step_nxt        = stlfw_pkg::UA_BEGIN;
          pos_left_nxt    = begin_count;
          text_active_nxt = begin_count != 5'd0;
          pad_nxt         = in_fill;
        end
        stlfw_pkg::OP_CHAR: begin
          if (text_active_r) begin
            if (in_value != 8'd0) begin
              busy_nxt     = 1'b1;
              step_nxt     = stlfw_pkg::UA_CHAR;
              pos_left_nxt = pos_left_r - 1'b1;
              if (pos_left_r == 5'd1) begin
                text_active_nxt = 1'b0;
              end
            end else begin
              // NUL closes the row, padding the rest when asked to.
              if (pad_r && (pos_left_r != 5'd0)) begin
                busy_nxt     = 1'b1;
                step_nxt     = stlfw_pkg::UA_PAD;
                loop_cnt_nxt = pos_left_r;
              end
              pos_left_nxt    = 5'd0;
              text_active_nxt = 1'b0;
            end
          end
        end
        stlfw_pkg::OP_REV: begin
          busy_nxt = 1'b1;
          step_nxt = stlfw_pkg::UA_REV;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded on each step, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_fe_nxt    = out_fe_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = step_byte;
      out_fe_nxt    = cw.frame_end;
      out_last_nxt  = cw.done && !jump;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      step_r        <= stlfw_pkg::UA_CMD;
      loop_cnt_r    <= 5'd0;
      text_active_r <= 1'b0;
      pos_left_r    <= 5'd0;
      pad_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      busy_r        <= busy_nxt;
      step_r        <= step_nxt;
      loop_cnt_r    <= loop_cnt_nxt;
      text_active_r <= text_active_nxt;
      pos_left_r    <= pos_left_nxt;
      pad_r         <= pad_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_fe_r   <= out_fe_nxt;
    out_last_r <= out_last_nxt;
    if (acc) begin
      value_r <= in_value;
      row_r   <= in_row;
      col_r   <= in_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_fe_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for serial_text_lcd_frame_writer: a predictor of the LCD
// wire bytes is checked against every output beat. Depends on stlfw_pkg and the block.

module testbench;

  localparam int ROW_LEN = stlfw_pkg::ROW_BYTES_DEF;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [7:0] NUL_CHAR = 8'h00;
  // Position command base for rows 0..3; row 0 is the last element listed.
  localparam logic [3:0][7:0] ROW_BASE = {8'h98, 8'h88, 8'h90, 8'h80};
  localparam int IDLE_PCT = 17;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 8;
  // The longest quiet stretch of a correct run comes from the output hold, so
  // this limit leaves a wide margin.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_end;
    logic       last;
  } lcd_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Predicted state of the open text row.
  logic       row_open = 1'b0;
  logic [4:0] slots_left = '0;
  logic       pad_row = 1'b0;

  lcd_beat_t expected_bytes[$];
  lcd_beat_t next_beat;

  bit steady_flow = 1'b0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int stall_count = 0;
  int mismatches = 0;
  int beats_checked = 0;
  int items_sent = 0;
  int items_effective = 0;
  int longest_item = 0;

  serial_text_lcd_frame_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One serial frame: sync byte, high nibble, low nibble moved up.
  function automatic void push_frame(input logic [7:0] sync, input logic [7:0] v);
    expected_bytes.push_back({sync, 1'b0, 1'b0});
    expected_bytes.push_back({v & stlfw_pkg::NIBBLE_MASK, 1'b0, 1'b0});
    expected_bytes.push_back({v[3:0], 4'h0, 1'b1, 1'b0});
  endfunction

  // Queues the wire bytes one input beat causes and updates the row state.
  function automatic int predict_lcd_bytes(input logic [2:0] op, input logic [1:0] row,
                                           input logic [2:0] col, input logic fill,
                                           input logic [7:0] value);
    int first;
    int span;
    int count;
    int k;
    lcd_beat_t tail_beat;
    first = expected_bytes.size();
    case (op)
      stlfw_pkg::OP_CMD:  push_frame(stlfw_pkg::SYNC_CMD, value);
      stlfw_pkg::OP_DATA: push_frame(stlfw_pkg::SYNC_DATA, value);
      stlfw_pkg::OP_BEGIN: begin
        span = 2 * col;
        count = (ROW_LEN > span) ? ROW_LEN - span : 0;
        if (count > stlfw_pkg::POS_LIMIT) count = stlfw_pkg::POS_LIMIT;
        push_frame(stlfw_pkg::SYNC_CMD, stlfw_pkg::CMD_BASIC);
        push_frame(stlfw_pkg::SYNC_CMD, ROW_BASE[row] + col);
        slots_left = count[4:0];
        row_open = (count != 0);
        pad_row = fill;
      end
      stlfw_pkg::OP_CHAR: begin
        if (row_open) begin
          if (value != NUL_CHAR) begin
            push_frame(stlfw_pkg::SYNC_DATA, value);
            slots_left = slots_left - 5'd1;
            if (slots_left == 5'd0) row_open = 1'b0;
          end else begin
            // The terminator pads the rest of the row only when asked to.
            if (pad_row) begin
              for (k = 0; k < slots_left; k++) begin
                push_frame(stlfw_pkg::SYNC_DATA, stlfw_pkg::SPACE_CHAR);
              end
            end
            slots_left = 5'd0;
            row_open = 1'b0;
          end
        end
      end
      stlfw_pkg::OP_REV: begin
        push_frame(stlfw_pkg::SYNC_CMD, stlfw_pkg::CMD_EXTENDED);
        push_frame(stlfw_pkg::SYNC_CMD, stlfw_pkg::CMD_REVERSE | {6'b0, row});
      end
      default: ;
    endcase
    if (expected_bytes.size() > first) begin
      tail_beat = expected_bytes.pop_back();
      tail_beat.last = 1'b1;
      expected_bytes.push_back(tail_beat);
    end
    return expected_bytes.size() - first;
  endfunction

  // Offers one beat on the input, waits for it to be taken, then predicts.
  task automatic send_item(input logic [2:0] op, input logic [1:0] row, input logic [2:0] col,
                           input logic fill, input logic [7:0] value);
    int produced;
    bit touched;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, value, fill, col, row};
    do @(posedge clk); while (!in_tready);
    touched = (op == stlfw_pkg::OP_CHAR) ? row_open : (op <= stlfw_pkg::OP_REV);
    produced = predict_lcd_bytes(op, row, col, fill, value);
    items_sent++;
    if (touched) items_effective++;
    if (produced > longest_item) longest_item = produced;
  endtask

  // Lowers the input and waits until every predicted byte has come out.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Any op, spare codes included, with random fields.
  task automatic send_noise();
    send_item(3'($urandom_range(OP_SPARE_LAST, stlfw_pkg::OP_CMD)), 2'($urandom_range(3)),
              3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // A text row: begin, a run of characters that may overflow, usually a NUL.
  task automatic send_text_burst();
    logic [2:0] col;
    int chars;
    int k;
    col = 3'($urandom_range(7));
    send_item(stlfw_pkg::OP_BEGIN, 2'($urandom_range(3)), col, 1'($urandom_range(1)),
              8'($urandom_range(255)));
    chars = $urandom_range(ROW_LEN - 2 * col + 1);
    for (k = 0; k < chars; k++) begin
      if ($urandom_range(9) == 0) send_noise();
      send_item(stlfw_pkg::OP_CHAR, 2'($urandom_range(3)), 3'($urandom_range(7)),
                1'($urandom_range(1)), 8'($urandom_range(255, 1)));
    end
    if ($urandom_range(4) != 0) begin
      send_item(stlfw_pkg::OP_CHAR, 2'($urandom_range(3)), 3'($urandom_range(7)),
                1'($urandom_range(1)), NUL_CHAR);
    end
  endtask

  task automatic test_raw_frames();
    send_item(stlfw_pkg::OP_CMD, 2'd0, 3'd0, 1'b0, 8'h00);
    send_item(stlfw_pkg::OP_CMD, 2'd3, 3'd7, 1'b1, 8'hFF);
    send_item(stlfw_pkg::OP_DATA, 2'd0, 3'd0, 1'b0, 8'h00);
    send_item(stlfw_pkg::OP_DATA, 2'd3, 3'd7, 1'b1, 8'hFF);
    drain_outputs();
  endtask

  task automatic test_reverse_rows();
    int r;
    for (r = 0; r < 4; r++) begin
      send_item(stlfw_pkg::OP_REV, 2'(r), 3'($urandom_range(7)), 1'($urandom_range(1)),
                8'($urandom_range(255)));
    end
    drain_outputs();
  endtask

  // Character with no open row, then the narrowest row filled past its end.
  task automatic test_row_limits();
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h55);
    send_item(stlfw_pkg::OP_BEGIN, 2'd1, 3'd7, 1'b0, 8'h00);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h41);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h42);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h43);
    drain_outputs();
  endtask

  // Begin over an open row, padded close, and the widest padded row.
  task automatic test_padding();
    send_item(stlfw_pkg::OP_BEGIN, 2'd2, 3'd0, 1'b1, 8'hFF);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h78);
    send_item(stlfw_pkg::OP_BEGIN, 2'd3, 3'd6, 1'b1, 8'h00);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'hFF);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, NUL_CHAR);
    send_item(stlfw_pkg::OP_BEGIN, 2'd0, 3'd0, 1'b1, 8'h00);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b1, NUL_CHAR);
    drain_outputs();
  endtask

  // A raw frame inside an open row must not disturb it; NUL closes silently.
  task automatic test_silent_close();
    send_item(stlfw_pkg::OP_BEGIN, 2'd1, 3'd3, 1'b0, 8'h00);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h7E);
    send_item(stlfw_pkg::OP_DATA, 2'd0, 3'd0, 1'b0, 8'h3C);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b1, NUL_CHAR);
    send_item(stlfw_pkg::OP_CHAR, 2'd0, 3'd0, 1'b0, 8'h41);
    drain_outputs();
  endtask

  task automatic test_spare_ops();
    send_item(OP_SPARE_FIRST, 2'($urandom_range(3)), 3'($urandom_range(7)), 1'b1, 8'hFF);
    send_item(OP_SPARE_LAST, 2'($urandom_range(3)), 3'($urandom_range(7)), 1'b0, 8'h00);
    drain_outputs();
  endtask

  // Mostly well-formed text rows, with stray items in between.
  task automatic test_random_traffic(input int target);
    int start;
    start = items_effective;
    while (items_effective - start < target) begin
      if ($urandom_range(9) < 7) send_text_burst();
      else send_noise();
    end
    drain_outputs();
  endtask

  task automatic test_no_idling();
    steady_flow <= 1'b1;
    test_random_traffic(55);
    steady_flow <= 1'b0;
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_output_hold();
    hold_toggle <= ~hold_toggle;
    test_random_traffic(45);
  endtask

  // Receiver: random idling, a steady stretch, and one long hold on request.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (steady_flow) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compares each output beat with the oldest predicted byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: output beat with nothing expected: byte %02h frame_end %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        next_beat = expected_bytes.pop_front();
        if (out_tdata !== next_beat.wire_byte) begin
          $display("%0t: wire_byte expected %02h actual %02h",
                   $time, next_beat.wire_byte, out_tdata);
          mismatches++;
        end
        if (out_tuser !== next_beat.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, next_beat.frame_end, out_tuser);
          mismatches++;
        end
        if (out_tlast !== next_beat.last) begin
          $display("%0t: last expected %0b actual %0b", $time, next_beat.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_raw_frames();
    test_reverse_rows();
    test_row_limits();
    test_padding();
    test_silent_close();
    test_spare_ops();
    test_random_traffic(130);
    test_no_idling();
    test_output_hold();
    $display("Run covered %0d input items (%0d acted on) and %0d checked output beats.",
             items_sent, items_effective, beats_checked);
    $display("Largest answer to one item: %0d beats; one %0d-cycle output hold included.",
             longest_item, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* serial_text_lcd_frame_writer.f */
design/stlfw_pkg.sv
design/stlfw_byte_unit.sv
design/serial_text_lcd_frame_writer.sv
verif/testbench.sv
